### rtl/core/lav_pkg.sv
// shared types and constants for the look-at view matrix block
// no dependencies; used by every module under rtl/core
package lav_pkg;

    localparam int AXIS_FRAC  = 30;
    localparam int FIFO_DEPTH = 2;

    // rounding offset for the q2.30 x q16.16 to q16.16 step
    localparam logic [63:0] ROUND_HALF = 64'd1 << (AXIS_FRAC - 1);
    localparam logic [33:0] POS_LIMIT  = 34'h0_7FFF_FFFF;
    localparam logic [33:0] NEG_LIMIT  = 34'h0_8000_0000;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_hint_x;
        logic signed [31:0] up_hint_y;
        logic signed [31:0] up_hint_z;
    } lav_in_t;

    typedef struct packed {
        logic signed [31:0] right_x;
        logic signed [31:0] right_y;
        logic signed [31:0] right_z;
        logic signed [31:0] upward_x;
        logic signed [31:0] upward_y;
        logic signed [31:0] upward_z;
        logic signed [31:0] forward_x;
        logic signed [31:0] forward_y;
        logic signed [31:0] forward_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } lav_out_t;

    // queued work: eye, up hint and the exact target minus eye
    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
        logic signed [32:0] d_x;
        logic signed [32:0] d_y;
        logic signed [32:0] d_z;
    } lav_job_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } lav_vec64_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } lav_vec32_t;

    // request to the normalizer
    typedef struct packed {
        logic       go;
        lav_vec64_t vec;
    } lav_norm_req_t;

    // answer from the normalizer
    typedef struct packed {
        logic       done;
        lav_vec32_t axis;
    } lav_norm_rsp_t;

endpackage

### rtl/core/lav_fifo.sv
// small job queue between the front and the back end
// depends on lav_pkg for the job type
module lav_fifo #(
    parameter int Depth = lav_pkg::FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lav_pkg::lav_job_t wdata,
    input  logic              pop,
    output lav_pkg::lav_job_t rdata,
    output logic              full,
    output logic              empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    lav_pkg::lav_job_t mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == FullCnt);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/lav_front.sv
// front end: takes a command beat, forms target minus eye and queues the job
// depends on lav_pkg for the input and job types
module lav_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lav_pkg::lav_in_t  item,
    output logic              busy,
    input  logic              queue_full,
    output logic              push,
    output lav_pkg::lav_job_t job
);

    logic              valid_reg;
    lav_pkg::lav_job_t job_reg;
    logic              accept;

    assign busy   = valid_reg && queue_full;
    assign accept = start && !busy;
    assign push   = valid_reg && !queue_full;
    assign job    = job_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg.eye_x <= item.eye_x;
            job_reg.eye_y <= item.eye_y;
            job_reg.eye_z <= item.eye_z;
            job_reg.up_x  <= item.up_hint_x;
            job_reg.up_y  <= item.up_hint_y;
            job_reg.up_z  <= item.up_hint_z;
            // full 33-bit difference, no wrap
            job_reg.d_x   <= 33'(item.target_x) - 33'(item.eye_x);
            job_reg.d_y   <= 33'(item.target_y) - 33'(item.eye_y);
            job_reg.d_z   <= 33'(item.target_z) - 33'(item.eye_z);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

### rtl/core/lav_norm.sv
// vector normalizer: scales to a common exponent, sums squares,
// takes an iterative square root and three iterative divides to q2.30
// depends on lav_pkg for the request and response types
module lav_norm (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lav_pkg::lav_norm_req_t req,
    output lav_pkg::lav_norm_rsp_t rsp
);

    typedef enum logic [2:0] {
        N_IDLE,
        N_SCAN,
        N_SCALE,
        N_SQUARE,
        N_SQRT,
        N_DSET,
        N_DIV,
        N_OUT
    } state_t;

    state_t      state_reg;
    logic [63:0] mag_reg [3];
    logic [2:0]  neg_reg;
    logic [63:0] or_reg;
    logic [2:0]  byte_reg;
    logic [6:0]  blen_reg;
    logic [29:0] scl_reg [3];
    logic [59:0] prod_reg;
    logic [61:0] sum_reg;
    logic [4:0]  cnt_reg;
    logic [30:0] root_reg;
    logic [32:0] rem_reg;
    logic [30:0] len_reg;
    logic [60:0] num_reg [3];
    logic [30:0] drem_reg [3];
    logic [30:0] quo_reg [3];
    lav_pkg::lav_vec32_t axis_reg;
    logic        done_reg;

    logic signed [63:0] vin [3];
    logic [63:0] mag_in [3];
    logic [2:0]  neg_in;
    logic [63:0] or_in;
    logic [7:0]  scan_byte;
    logic [2:0]  scan_pos;
    logic [6:0]  scan_len;
    logic [29:0] scl_val [3];
    logic [5:0]  sq_idx;
    logic [34:0] sq_r;
    logic [34:0] sq_t;
    logic        sq_ge;
    logic [30:0] len_val;
    logic [60:0] num_val [3];
    logic [31:0] dv_r [3];
    logic [2:0]  dv_ge;

    assign vin[0] = req.vec.x;
    assign vin[1] = req.vec.y;
    assign vin[2] = req.vec.z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_in[i] = vin[i][63];
            mag_in[i] = neg_in[i] ? 64'(-vin[i]) : 64'(vin[i]);
        end
        or_in = mag_in[0] | mag_in[1] | mag_in[2];
    end

    // top set bit of the current byte of the or-ed magnitudes
    always_comb
    begin
        scan_byte = or_reg[{byte_reg, 3'b000} +: 8];
        scan_pos  = '0;
        for (int j = 0; j < 8; j++)
        begin
            if (scan_byte[j])
            begin
                scan_pos = 3'(j);
            end
        end
        scan_len = 7'({byte_reg, 3'b000}) + 7'(scan_pos) + 7'd1;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (blen_reg > 7'd30)
            begin
                scl_val[i] = 30'(mag_reg[i] >> (blen_reg - 7'd30));
            end
            else
            begin
                scl_val[i] = 30'(mag_reg[i] << (7'd30 - blen_reg));
            end
        end
    end

    // one root bit per cycle
    always_comb
    begin
        sq_idx = {cnt_reg, 1'b0};
        sq_r   = {rem_reg, sum_reg[sq_idx +: 2]};
        sq_t   = {2'b00, root_reg, 2'b01};
        sq_ge  = (sq_r >= sq_t);
    end

    always_comb
    begin
        len_val = (root_reg == '0) ? 31'd1 : root_reg;
        for (int i = 0; i < 3; i++)
        begin
            num_val[i] = {1'b0, scl_reg[i], 30'd0} + 61'(len_val >> 1);
        end
    end

    // one quotient bit per cycle in each of three lanes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_r[i]  = {drem_reg[i], num_reg[i][cnt_reg]};
            dv_ge[i] = (dv_r[i] >= {1'b0, len_reg});
        end
    end

    assign rsp.done = done_reg;
    assign rsp.axis = axis_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
            begin
                if (req.go)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_in[i];
                        quo_reg[i] <= '0;
                    end
                    neg_reg  <= neg_in;
                    or_reg   <= or_in;
                    byte_reg <= 3'd7;
                end
            end
            N_SCAN:
            begin
                byte_reg <= byte_reg - 3'd1;
                blen_reg <= scan_len;
            end
            N_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    scl_reg[i] <= scl_val[i];
                end
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            N_SQUARE:
            begin
                if (cnt_reg < 5'd3)
                begin
                    prod_reg <= scl_reg[cnt_reg[1:0]] * scl_reg[cnt_reg[1:0]];
                end
                if (cnt_reg != '0)
                begin
                    sum_reg <= sum_reg + 62'(prod_reg);
                end
                cnt_reg  <= (cnt_reg == 5'd3) ? 5'd30 : cnt_reg + 5'd1;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            N_SQRT:
            begin
                rem_reg  <= sq_ge ? 33'(sq_r - sq_t) : 33'(sq_r);
                root_reg <= {root_reg[29:0], sq_ge};
                cnt_reg  <= cnt_reg - 5'd1;
            end
            N_DSET:
            begin
                len_reg <= len_val;
                for (int i = 0; i < 3; i++)
                begin
                    num_reg[i]  <= num_val[i];
                    drem_reg[i] <= {1'b0, num_val[i][60:31]};
                end
                cnt_reg <= 5'd30;
            end
            N_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[i] <= dv_ge[i] ? 31'(dv_r[i] - {1'b0, len_reg})
                                            : 31'(dv_r[i]);
                    quo_reg[i]  <= {quo_reg[i][29:0], dv_ge[i]};
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            N_OUT:
            begin
                axis_reg.x <= neg_reg[0] ? -$signed({1'b0, quo_reg[0]})
                                         : $signed({1'b0, quo_reg[0]});
                axis_reg.y <= neg_reg[1] ? -$signed({1'b0, quo_reg[1]})
                                         : $signed({1'b0, quo_reg[1]});
                axis_reg.z <= neg_reg[2] ? -$signed({1'b0, quo_reg[2]})
                                         : $signed({1'b0, quo_reg[2]});
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == N_OUT);
            unique case (state_reg)
                N_IDLE:
                begin
                    if (req.go)
                    begin
                        // zero-length vector skips straight to a zero axis
                        state_reg <= (or_in == '0) ? N_OUT : N_SCAN;
                    end
                end
                N_SCAN:
                begin
                    if (scan_byte != '0)
                    begin
                        state_reg <= N_SCALE;
                    end
                end
                N_SCALE:
                begin
                    state_reg <= N_SQUARE;
                end
                N_SQUARE:
                begin
                    if (cnt_reg == 5'd3)
                    begin
                        state_reg <= N_SQRT;
                    end
                end
                N_SQRT:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= N_DSET;
                    end
                end
                N_DSET:
                begin
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= N_OUT;
                    end
                end
                N_OUT:
                begin
                    state_reg <= N_IDLE;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/lav_back.sv
// back end: sequences the three normalizations, the two cross products
// and the three dot products on one shared 32x32 multiplier
// depends on lav_pkg and on lav_norm
module lav_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  lav_pkg::lav_job_t job,
    output logic              pop,
    output logic              done,
    output lav_pkg::lav_out_t result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FWD_GO,
        S_FWD_WAIT,
        S_X1,
        S_RGT_GO,
        S_RGT_WAIT,
        S_X2,
        S_UPW_GO,
        S_UPW_WAIT,
        S_DOT,
        S_FINISH
    } state_t;

    state_t             state_reg;
    lav_pkg::lav_job_t  job_reg;
    logic signed [31:0] fwd_reg [3];
    logic signed [31:0] rgt_reg [3];
    logic signed [31:0] upw_reg [3];
    logic signed [63:0] acc_reg [3];
    logic signed [63:0] prod_reg;
    logic [1:0]         dest_reg;
    logic               sub_reg;
    logic [3:0]         cnt_reg;
    lav_pkg::lav_out_t  result_reg;
    logic               done_reg;

    lav_pkg::lav_norm_req_t norm_req;
    lav_pkg::lav_norm_rsp_t norm_rsp;

    logic signed [31:0] eye [3];
    logic signed [31:0] up [3];
    logic signed [31:0] axis_in [3];
    logic signed [31:0] va [3];
    logic signed [31:0] vb [3];
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic [1:0]         mul_dest;
    logic               mul_sub;
    logic [3:0]         mul_count;
    logic               in_mul;

    function automatic logic signed [31:0] neg_round(input logic signed [63:0] s);
        logic [63:0] mag;
        logic [33:0] q;
        logic [33:0] neg_q;
        mag   = s[63] ? 64'(-s) : 64'(s);
        q     = 34'((mag + lav_pkg::ROUND_HALF) >> lav_pkg::AXIS_FRAC);
        neg_q = 34'd0 - q;
        if (!s[63] && (s != '0))
        begin
            return (q > lav_pkg::NEG_LIMIT) ? 32'sh8000_0000 : $signed(neg_q[31:0]);
        end
        return (q > lav_pkg::POS_LIMIT) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    endfunction

    lav_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (norm_req),
        .rsp   (norm_rsp)
    );

    assign eye[0] = job_reg.eye_x;
    assign eye[1] = job_reg.eye_y;
    assign eye[2] = job_reg.eye_z;
    assign up[0]  = job_reg.up_x;
    assign up[1]  = job_reg.up_y;
    assign up[2]  = job_reg.up_z;

    assign axis_in[0] = norm_rsp.axis.x;
    assign axis_in[1] = norm_rsp.axis.y;
    assign axis_in[2] = norm_rsp.axis.z;

    assign pop    = (state_reg == S_IDLE) && !queue_empty;
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        norm_req.go = (state_reg == S_FWD_GO) || (state_reg == S_RGT_GO)
                   || (state_reg == S_UPW_GO);
        if (state_reg == S_FWD_GO)
        begin
            norm_req.vec.x = 64'(job_reg.d_x);
            norm_req.vec.y = 64'(job_reg.d_y);
            norm_req.vec.z = 64'(job_reg.d_z);
        end
        else
        begin
            norm_req.vec.x = acc_reg[0];
            norm_req.vec.y = acc_reg[1];
            norm_req.vec.z = acc_reg[2];
        end
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            va[i] = (state_reg == S_X1) ? up[i] : fwd_reg[i];
            vb[i] = (state_reg == S_X1) ? fwd_reg[i] : rgt_reg[i];
        end
        mul_a    = '0;
        mul_b    = '0;
        mul_dest = '0;
        mul_sub  = 1'b0;
        in_mul   = (state_reg == S_X1) || (state_reg == S_X2) || (state_reg == S_DOT);
        mul_count = (state_reg == S_DOT) ? 4'd9 : 4'd6;
        if (state_reg == S_DOT)
        begin
            unique case (cnt_reg)
                4'd0:    begin mul_a = rgt_reg[0]; mul_b = eye[0]; mul_dest = 2'd0; end
                4'd1:    begin mul_a = rgt_reg[1]; mul_b = eye[1]; mul_dest = 2'd0; end
                4'd2:    begin mul_a = rgt_reg[2]; mul_b = eye[2]; mul_dest = 2'd0; end
                4'd3:    begin mul_a = upw_reg[0]; mul_b = eye[0]; mul_dest = 2'd1; end
                4'd4:    begin mul_a = upw_reg[1]; mul_b = eye[1]; mul_dest = 2'd1; end
                4'd5:    begin mul_a = upw_reg[2]; mul_b = eye[2]; mul_dest = 2'd1; end
                4'd6:    begin mul_a = fwd_reg[0]; mul_b = eye[0]; mul_dest = 2'd2; end
                4'd7:    begin mul_a = fwd_reg[1]; mul_b = eye[1]; mul_dest = 2'd2; end
                4'd8:    begin mul_a = fwd_reg[2]; mul_b = eye[2]; mul_dest = 2'd2; end
                default: begin end
            endcase
        end
        else
        begin
            // cross product terms, odd steps subtract
            unique case (cnt_reg)
                4'd0:    begin mul_a = va[1]; mul_b = vb[2]; end
                4'd1:    begin mul_a = va[2]; mul_b = vb[1]; end
                4'd2:    begin mul_a = va[2]; mul_b = vb[0]; end
                4'd3:    begin mul_a = va[0]; mul_b = vb[2]; end
                4'd4:    begin mul_a = va[0]; mul_b = vb[1]; end
                4'd5:    begin mul_a = va[1]; mul_b = vb[0]; end
                default: begin end
            endcase
            mul_dest = 2'(cnt_reg >> 1);
            mul_sub  = cnt_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job;
        end
        if (norm_rsp.done)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (state_reg == S_FWD_WAIT)
                begin
                    fwd_reg[i] <= axis_in[i];
                end
                if (state_reg == S_RGT_WAIT)
                begin
                    rgt_reg[i] <= axis_in[i];
                end
                if (state_reg == S_UPW_WAIT)
                begin
                    upw_reg[i] <= axis_in[i];
                end
            end
        end
        if (norm_rsp.done)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (in_mul && (cnt_reg != '0))
        begin
            acc_reg[dest_reg] <= sub_reg ? acc_reg[dest_reg] - prod_reg
                                         : acc_reg[dest_reg] + prod_reg;
        end
        if (in_mul && (cnt_reg < mul_count))
        begin
            prod_reg <= mul_a * mul_b;
            dest_reg <= mul_dest;
            sub_reg  <= mul_sub;
        end
        if (state_reg == S_FINISH)
        begin
            result_reg.right_x   <= rgt_reg[0];
            result_reg.right_y   <= rgt_reg[1];
            result_reg.right_z   <= rgt_reg[2];
            result_reg.upward_x  <= upw_reg[0];
            result_reg.upward_y  <= upw_reg[1];
            result_reg.upward_z  <= upw_reg[2];
            result_reg.forward_x <= fwd_reg[0];
            result_reg.forward_y <= fwd_reg[1];
            result_reg.forward_z <= fwd_reg[2];
            result_reg.shift_x   <= neg_round(acc_reg[0]);
            result_reg.shift_y   <= neg_round(acc_reg[1]);
            result_reg.shift_z   <= neg_round(acc_reg[2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_FINISH);
            if (in_mul)
            begin
                cnt_reg <= (cnt_reg == mul_count) ? '0 : cnt_reg + 4'd1;
            end
            unique case (state_reg)
                S_IDLE:     if (pop) state_reg <= S_FWD_GO;
                S_FWD_GO:   state_reg <= S_FWD_WAIT;
                S_FWD_WAIT: if (norm_rsp.done) state_reg <= S_X1;
                S_X1:       if (cnt_reg == mul_count) state_reg <= S_RGT_GO;
                S_RGT_GO:   state_reg <= S_RGT_WAIT;
                S_RGT_WAIT: if (norm_rsp.done) state_reg <= S_X2;
                S_X2:       if (cnt_reg == mul_count) state_reg <= S_UPW_GO;
                S_UPW_GO:   state_reg <= S_UPW_WAIT;
                S_UPW_WAIT: if (norm_rsp.done) state_reg <= S_DOT;
                S_DOT:      if (cnt_reg == mul_count) state_reg <= S_FINISH;
                S_FINISH:   state_reg <= S_IDLE;
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/look_at_view_matrix_top.sv
// look-at view matrix: command in, one strobed result beat out
// depends on lav_pkg, lav_front, lav_fifo and lav_back
//
// usage:
//   a command beat is taken on a rising edge with start high and busy low;
//   item carries eye, target and up hint in signed q16.16.
//   each result beat is shown on result for exactly one cycle with done
//   high; the receiver must take it then, there is no back pressure.
//   result holds the right, upward and forward axes in q2.30 and the three
//   saturated q16.16 translation terms.
// timing:
//   the front end registers the beat and forms target minus eye; a queue
//   of FifoDepth jobs sits in front of the back end, so start may be
//   taken on back-to-back cycles until the queue fills.
//   the back end handles one job at a time: three passes through the
//   shared normalizer (exponent scan, squaring, square root, divide and
//   handoff), the two cross products and the dot products on the shared
//   multiplier, and pickup and finish; that sets the sustained rate.
//   a zero-length vector skips the normalizer straight to a zero axis.
// reset:
//   rst_n clears the queue and all sequencers; no result is pending.
module look_at_view_matrix_top #(
    parameter int FifoDepth = lav_pkg::FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lav_pkg::lav_in_t  item,
    output logic              busy,
    output logic              done,
    output lav_pkg::lav_out_t result
);

    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_empty;
    lav_pkg::lav_job_t front_job;
    lav_pkg::lav_job_t queue_job;

    lav_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .busy       (busy),
        .queue_full (queue_full),
        .push       (push),
        .job        (front_job)
    );

    lav_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_job),
        .pop   (pop),
        .rdata (queue_job),
        .full  (queue_full),
        .empty (queue_empty)
    );

    lav_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .job         (queue_job),
        .pop         (pop),
        .done        (done),
        .result      (result)
    );

endmodule
